FILE: rtl/kalman_filter_2state_top_assert.svh
// ---------------------------------------------------------------------------
// kalman_filter_2state_top_assert.svh
// Assertion macros used by the filter top level.
// ---------------------------------------------------------------------------
`ifndef KALMAN_FILTER_2STATE_TOP_ASSERT_SVH
`define KALMAN_FILTER_2STATE_TOP_ASSERT_SVH

// Same-cycle implication.
`define KF2_ASSERT_SAME(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("kf2 same-cycle check failed");

// Next-cycle implication.
`define KF2_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("kf2 next-cycle check failed");

`endif

FILE: rtl/kf2_pkg.sv
// ---------------------------------------------------------------------------
// kf2_pkg
// Widths, register codes, types and saturation helper for the 2-state filter.
// ---------------------------------------------------------------------------
package kf2_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  // Unsigned variance-style registers (R, initial variance)
  localparam int VAR_W = DATA_WIDTH - 1;

  // Divider: |numerator| << FRAC_BITS, divisor S (positive)
  localparam int NUM_W = DATA_WIDTH + FRAC_BITS + 1;
  localparam int DEN_W = DATA_WIDTH;

  // Floor-shifted product and exact working width for sums
  localparam int PROD_W = 2 * DATA_WIDTH - FRAC_BITS;
  localparam int WIDE_W = DATA_WIDTH + FRAC_BITS + 2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MOTION_POS = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_MOTION_VEL = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_VAR   = CFG_IDX_W'(3);

  localparam logic [VAR_W-1:0] MEAS_NOISE_RST = VAR_W'(1) << FRAC_BITS;
  localparam logic [VAR_W-1:0] INIT_VAR_RST   = VAR_W'(1000) << FRAC_BITS;

  localparam logic signed [WIDE_W-1:0] WIDE_MAX =
    {{(WIDE_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [WIDE_W-1:0] WIDE_MIN = ~WIDE_MAX;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] val;
    logic                         clip;
  } sat_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // Clip an exact wide value to the signed data range.
  function automatic sat_t sat_q(input logic signed [WIDE_W-1:0] x);
    sat_t r;
    if (x > WIDE_MAX) begin
      r.val  = {1'b0, {(DATA_WIDTH-1){1'b1}}};
      r.clip = 1'b1;
    end else if (x < WIDE_MIN) begin
      r.val  = {1'b1, {(DATA_WIDTH-1){1'b0}}};
      r.clip = 1'b1;
    end else begin
      r.val  = x[DATA_WIDTH-1:0];
      r.clip = 1'b0;
    end
    return r;
  endfunction

endpackage

FILE: rtl/kf2_if.sv
// ---------------------------------------------------------------------------
// kf2_if
// Valid/ready channels: measurement requests in, estimate requests out.
// ---------------------------------------------------------------------------
interface kf2_meas_if import kf2_pkg::*;;
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] measurement;
  logic                         restart;

  modport source (output valid, output measurement, output restart, input ready);
  modport sink   (input valid, input measurement, input restart, output ready);
endinterface

interface kf2_est_if import kf2_pkg::*;;
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] pos_est;
  logic signed [DATA_WIDTH-1:0] vel_est;
  logic signed [DATA_WIDTH-1:0] cov_pos_pos;
  logic signed [DATA_WIDTH-1:0] cov_pos_vel;
  logic signed [DATA_WIDTH-1:0] cov_vel_pos;
  logic signed [DATA_WIDTH-1:0] cov_vel_vel;
  logic                         saturated;

  modport source (output valid, output pos_est, output vel_est, output cov_pos_pos,
                  output cov_pos_vel, output cov_vel_pos, output cov_vel_vel,
                  output saturated, input ready);
  modport sink   (input valid, input pos_est, input vel_est, input cov_pos_pos,
                  input cov_pos_vel, input cov_vel_pos, input cov_vel_vel,
                  input saturated, output ready);
endinterface

FILE: rtl/kf2_div.sv
// ---------------------------------------------------------------------------
// kf2_div
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module kf2_div import kf2_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic [NUM_W-1:0] quotient,
  output div_status_t      status
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign rem_sh = {rem, quotient[NUM_W-1]};
  assign diff   = rem_sh - {1'b0, dvs};
  assign ge     = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CNT_W'(NUM_W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quotient <= {quotient[NUM_W-2:0], ge};
    end
  end

  assign status.busy = busy;
  assign status.done = done;

endmodule

FILE: rtl/kf2_mul.sv
// ---------------------------------------------------------------------------
// kf2_mul
// Shared signed multiplier, product floored by FRAC_BITS and registered.
// ---------------------------------------------------------------------------
module kf2_mul import kf2_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [DATA_WIDTH-1:0] op_a,
  input  logic signed [DATA_WIDTH-1:0] op_b,
  output logic signed [PROD_W-1:0]     prod,
  output logic                         done
);

  logic signed [2*DATA_WIDTH-1:0] full;

  assign full = op_a * op_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
  end

  // arithmetic shift of a signed value floors toward minus infinity
  always_ff @(posedge clk) begin
    if (start) begin
      prod <= PROD_W'(full >>> FRAC_BITS);
    end
  end

endmodule

FILE: rtl/kalman_filter_2state_top.sv
// ---------------------------------------------------------------------------
// kalman_filter_2state_top
// Two-state constant-velocity Kalman filter, Q16.16, position measurement.
// ---------------------------------------------------------------------------
// Each measurement request runs an update (innovation, S = P00 + R, gains
// P00/S and P10/S, state and covariance correction) and then a prediction
// with F = [1 1; 0 1] plus the motion registers, no process noise. One
// estimate request comes out per measurement. A new measurement is accepted
// only once the previous one is finished and its estimate is loaded into
// the output register. The bit-serial divider runs two 49-step divisions
// per item. When S is not positive the divisions are skipped. The six
// multiplies share one 32x32 multiplier. The finished estimate sits in an
// output register, so a new measurement is accepted while it waits.
// Registers are written in any cycle the write enable is high; change them
// only while no measurement is in flight. The saturated flag is set when
// any intermediate or final value clipped to the 32-bit range.
// ---------------------------------------------------------------------------
`include "kalman_filter_2state_top_assert.svh"

module kalman_filter_2state_top import kf2_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [DATA_WIDTH-1:0] cfg_data,
  kf2_meas_if.sink              meas,
  kf2_est_if.source             est
);

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_INNOV = 4'd1;
  localparam logic [3:0] S_DIV0  = 4'd2;
  localparam logic [3:0] S_WAIT0 = 4'd3;
  localparam logic [3:0] S_DIV1  = 4'd4;
  localparam logic [3:0] S_WAIT1 = 4'd5;
  localparam logic [3:0] S_MUL   = 4'd6;
  localparam logic [3:0] S_ACC   = 4'd7;
  localparam logic [3:0] S_PRED  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  // multiply slots: updated p, v, a, b, c, d
  localparam int UPD_N = 6;
  localparam int MIDX_W = $clog2(UPD_N);
  localparam logic [MIDX_W-1:0] M_P = MIDX_W'(0);
  localparam logic [MIDX_W-1:0] M_V = MIDX_W'(1);
  localparam logic [MIDX_W-1:0] M_A = MIDX_W'(2);
  localparam logic [MIDX_W-1:0] M_B = MIDX_W'(3);
  localparam logic [MIDX_W-1:0] M_C = MIDX_W'(4);
  localparam logic [MIDX_W-1:0] M_D = MIDX_W'(5);

  // config registers
  logic [VAR_W-1:0]             meas_noise_var;
  logic signed [DATA_WIDTH-1:0] motion_pos;
  logic signed [DATA_WIDTH-1:0] motion_vel;
  logic [VAR_W-1:0]             initial_variance;

  // filter state
  logic signed [DATA_WIDTH-1:0] position;
  logic signed [DATA_WIDTH-1:0] velocity;
  logic signed [DATA_WIDTH-1:0] var_pp;
  logic signed [DATA_WIDTH-1:0] var_pv;
  logic signed [DATA_WIDTH-1:0] var_vp;
  logic signed [DATA_WIDTH-1:0] var_vv;

  // per-item working registers
  logic [3:0]                   state;
  logic [3:0]                   state_next;
  logic [MIDX_W-1:0]            midx;
  logic signed [DATA_WIDTH-1:0] z;
  logic signed [DATA_WIDTH-1:0] y;
  logic signed [DATA_WIDTH-1:0] k0;
  logic signed [DATA_WIDTH-1:0] k1;
  logic [DEN_W-1:0]             s_den;
  logic                         s_pos;
  logic                         clip;
  logic signed [DATA_WIDTH-1:0] upd [UPD_N];

  // shared units
  logic                         div_start;
  logic [NUM_W-1:0]             div_num;
  logic [NUM_W-1:0]             div_quo;
  div_status_t                  div_stat;
  logic                         mul_start;
  logic signed [DATA_WIDTH-1:0] mul_a;
  logic signed [DATA_WIDTH-1:0] mul_b;
  logic signed [PROD_W-1:0]     mul_prod;
  logic                         mul_done;

  // combinational datapath
  logic                         accept;
  logic                         out_load;
  logic signed [WIDE_W-1:0]     s_sum;
  sat_t                         y_sat;
  logic signed [DATA_WIDTH-1:0] num_sel;
  logic [DATA_WIDTH:0]          num_mag;
  logic signed [WIDE_W-1:0]     quo_signed;
  sat_t                         k_sat;
  logic signed [DATA_WIDTH-1:0] acc_base;
  logic                         acc_add;
  logic signed [WIDE_W-1:0]     acc_sum;
  sat_t                         acc_sat;
  sat_t                         pos_sat;
  sat_t                         vel_sat;
  sat_t                         pp_sat;
  sat_t                         pv_sat;
  sat_t                         vp_sat;
  sat_t                         vv_sat;

  assign accept   = meas.valid && meas.ready;
  assign meas.ready = (state == S_IDLE);
  assign out_load = (state == S_DONE) && (!est.valid || est.ready);

  // ---- configuration port ----
  always_ff @(posedge clk) begin
    if (rst) begin
      meas_noise_var   <= MEAS_NOISE_RST;
      motion_pos       <= '0;
      motion_vel       <= '0;
      initial_variance <= INIT_VAR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MEAS_NOISE: meas_noise_var   <= cfg_data[VAR_W-1:0];
        CFG_MOTION_POS: motion_pos       <= cfg_data;
        CFG_MOTION_VEL: motion_vel       <= cfg_data;
        CFG_INIT_VAR:   initial_variance <= cfg_data[VAR_W-1:0];
      endcase
    end
  end

  // ---- update: innovation and S ----
  assign y_sat = sat_q(WIDE_W'(z) - WIDE_W'(position));
  assign s_sum = WIDE_W'(var_pp) + WIDE_W'($signed({1'b0, meas_noise_var}));

  // ---- gain division: |num| << FRAC_BITS over S, sign applied after ----
  assign num_sel   = (state == S_DIV0) ? var_pp : var_vp;
  assign num_mag   = num_sel[DATA_WIDTH-1] ? -{num_sel[DATA_WIDTH-1], num_sel}
                                            :  {num_sel[DATA_WIDTH-1], num_sel};
  assign div_num   = {num_mag, {FRAC_BITS{1'b0}}};
  assign div_start = (state == S_DIV0) || (state == S_DIV1);

  // sign of the numerator being divided: var_pp while waiting on k0
  assign quo_signed = ((state == S_WAIT0) ? var_pp[DATA_WIDTH-1] : var_vp[DATA_WIDTH-1])
                      ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
  assign k_sat = sat_q(quo_signed);

  kf2_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (s_den),
    .quotient (div_quo),
    .status   (div_stat)
  );

  // ---- correction multiplies, one slot per pass ----
  assign mul_start = (state == S_MUL);

  always_comb begin
    mul_a    = k1;
    mul_b    = var_pv;
    acc_base = var_vv;
    acc_add  = 1'b0;
    unique case (midx)
      M_P: begin mul_a = k0; mul_b = y;      acc_base = position; acc_add = 1'b1; end
      M_V: begin mul_a = k1; mul_b = y;      acc_base = velocity; acc_add = 1'b1; end
      M_A: begin mul_a = k0; mul_b = var_pp; acc_base = var_pp; end
      M_B: begin mul_a = k0; mul_b = var_pv; acc_base = var_pv; end
      M_C: begin mul_a = k1; mul_b = var_pp; acc_base = var_vp; end
      M_D: begin mul_a = k1; mul_b = var_pv; acc_base = var_vv; end
      default: begin end
    endcase
  end

  assign acc_sum = acc_add ? WIDE_W'(acc_base) + WIDE_W'(mul_prod)
                           : WIDE_W'(acc_base) - WIDE_W'(mul_prod);
  assign acc_sat = sat_q(acc_sum);

  kf2_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .prod  (mul_prod),
    .done  (mul_done)
  );

  // ---- prediction: x = F x + u, P = F P F' ----
  assign pos_sat = sat_q(WIDE_W'(upd[M_P]) + WIDE_W'(upd[M_V]) + WIDE_W'(motion_pos));
  assign vel_sat = sat_q(WIDE_W'(upd[M_V]) + WIDE_W'(motion_vel));
  assign pp_sat  = sat_q(WIDE_W'(upd[M_A]) + WIDE_W'(upd[M_B])
                       + WIDE_W'(upd[M_C]) + WIDE_W'(upd[M_D]));
  assign pv_sat  = sat_q(WIDE_W'(upd[M_B]) + WIDE_W'(upd[M_D]));
  assign vp_sat  = sat_q(WIDE_W'(upd[M_C]) + WIDE_W'(upd[M_D]));
  assign vv_sat  = sat_q(WIDE_W'(upd[M_D]));

  // ---- sequencer ----
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept) state_next = S_INNOV;
      S_INNOV: state_next = (s_sum > 0) ? S_DIV0 : S_MUL;
      S_DIV0:  state_next = S_WAIT0;
      S_WAIT0: if (div_stat.done) state_next = S_DIV1;
      S_DIV1:  state_next = S_WAIT1;
      S_WAIT1: if (div_stat.done) state_next = S_MUL;
      S_MUL:   state_next = S_ACC;
      S_ACC:   state_next = (midx == M_D) ? S_PRED : S_MUL;
      S_PRED:  state_next = S_DONE;
      S_DONE:  if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      midx  <= M_P;
    end else begin
      state <= state_next;
      if (state == S_INNOV) begin
        midx <= M_P;
      end else if (state == S_ACC) begin
        midx <= midx + MIDX_W'(1);
      end
    end
  end

  // filter state: restart load on accept, prediction write-back
  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      velocity <= '0;
      var_pp   <= DATA_WIDTH'(INIT_VAR_RST);
      var_pv   <= '0;
      var_vp   <= '0;
      var_vv   <= DATA_WIDTH'(INIT_VAR_RST);
    end else if (accept && meas.restart) begin
      position <= '0;
      velocity <= '0;
      var_pp   <= DATA_WIDTH'(initial_variance);
      var_pv   <= '0;
      var_vp   <= '0;
      var_vv   <= DATA_WIDTH'(initial_variance);
    end else if (state == S_PRED) begin
      position <= pos_sat.val;
      velocity <= vel_sat.val;
      var_pp   <= pp_sat.val;
      var_pv   <= pv_sat.val;
      var_vp   <= vp_sat.val;
      var_vv   <= vv_sat.val;
    end
  end

  // clip flag collects every saturation of the item
  always_ff @(posedge clk) begin
    if (rst) begin
      clip <= 1'b0;
    end else begin
      priority case (1'b1)
        accept:                            clip <= 1'b0;
        state == S_INNOV:                  clip <= clip | y_sat.clip;
        (state == S_WAIT0 || state == S_WAIT1) && div_stat.done:
                                           clip <= clip | k_sat.clip;
        state == S_ACC:                    clip <= clip | acc_sat.clip;
        state == S_PRED:                   clip <= clip | pos_sat.clip | vel_sat.clip
                                                  | pp_sat.clip | pv_sat.clip
                                                  | vp_sat.clip | vv_sat.clip;
        default:                           clip <= clip;
      endcase
    end
  end

  // working payload, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      z <= meas.measurement;
    end
    if (state == S_INNOV) begin
      y     <= y_sat.val;
      s_den <= s_sum[DEN_W-1:0];
      s_pos <= (s_sum > 0);
      k0    <= '0;
      k1    <= '0;
    end
    if (state == S_WAIT0 && div_stat.done) begin
      k0 <= k_sat.val;
    end
    if (state == S_WAIT1 && div_stat.done) begin
      k1 <= k_sat.val;
    end
    if (state == S_ACC) begin
      upd[midx] <= acc_sat.val;
    end
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      est.valid <= 1'b0;
    end else if (out_load) begin
      est.valid <= 1'b1;
    end else if (est.ready) begin
      est.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      est.pos_est     <= position;
      est.vel_est     <= velocity;
      est.cov_pos_pos <= var_pp;
      est.cov_pos_vel <= var_pv;
      est.cov_vel_pos <= var_vp;
      est.cov_vel_vel <= var_vv;
      est.saturated   <= clip;
    end
  end

  // ---- checks ----
  `KF2_ASSERT_NEXT(a_busy_after_accept, clk, rst, accept, !meas.ready)
  `KF2_ASSERT_SAME(a_div_free_on_start, clk, rst, div_start, !div_stat.busy)
  `KF2_ASSERT_SAME(a_prod_ready_on_acc, clk, rst, state == S_ACC, mul_done)
  `KF2_ASSERT_SAME(a_div_only_pos_s, clk, rst, state == S_DIV1, s_pos)

endmodule
